[rtl/core/ibpt_pkg.sv]
// Shared types, constants and the frame bit lookup for the bus pulse transmitter.
// No dependencies; the front, queue, engine and top level import it.
package ibpt_pkg;

  localparam int ZONE_FRAME_BITS    = 120;
  localparam int PROGRAM_FRAME_BITS = 56;
  localparam int MAX_ZONE           = 48;
  localparam int MAX_MINUTES        = 240;
  localparam int PROGRAM_COUNT      = 4;

  // frame field positions
  localparam int ZONE_FIELD_BASE = 23;
  localparam int TIME_FIELD_BASE = 31;
  localparam int FIELD_STRIDE    = 13;
  localparam int FIELD_REPEATS   = 6;
  localparam int PROG_FIELD_BASE = 31;

  localparam int TICK_W      = 20;
  localparam int BIT_IDX_W   = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int SHORT_REG_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT   = 3'd0,
    CFG_LONG    = 3'd1,
    CFG_START   = 3'd2,
    CFG_RST_HI  = 3'd3,
    CFG_RST_LO  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ZONE = 2'd1,
    REQ_PROG = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ZONE = 3'd1,
    ST_BAD_TIME = 3'd2,
    ST_BAD_PROG = 3'd3,
    ST_BUSY     = 3'd4
  } status_t;

  // classified command as it travels from front to engine
  typedef struct packed {
    req_t        req;
    status_t     check;
    logic [5:0]  zone_index;
    logic [7:0]  minutes;
    logic [1:0]  prog_index;
  } cmd_t;

  // result beat, line_level in bit 0
  typedef struct packed {
    logic    frame_done;
    status_t status_code;
    logic    status_valid;
    logic    busy_res;
    logic    line_level;
  } result_t;

  function automatic logic frame_bit(input logic                 is_zone,
                                     input logic [BIT_IDX_W-1:0] idx,
                                     input logic [5:0]           zone_index,
                                     input logic [7:0]           minutes,
                                     input logic [1:0]           prog_index);
    logic       bit_v;
    logic [3:0] nib;
    logic [2:0] zoff;
    logic [1:0] toff;
    int         zp;
    int         tp;
    bit_v = 1'b0;
    nib   = 4'd0;
    zoff  = 3'd0;
    toff  = 2'd0;
    zp    = 0;
    tp    = 0;
    if (is_zone) begin
      if (idx >= BIT_IDX_W'(ZONE_FRAME_BITS)) begin
        bit_v = 1'b1;   // trailing one
      end else begin
        for (int k = 0; k < FIELD_REPEATS; k++) begin
          zp = ZONE_FIELD_BASE + FIELD_STRIDE * k;
          tp = TIME_FIELD_BASE + FIELD_STRIDE * k;
          if ((int'(idx) >= zp) && (int'(idx) < zp + 6)) begin
            zoff  = 3'(idx - BIT_IDX_W'(zp));
            bit_v = zone_index[zoff];
          end
          if ((int'(idx) >= tp) && (int'(idx) < tp + 4)) begin
            nib   = (k % 2 == 1) ? minutes[3:0] : minutes[7:4];
            toff  = 2'(idx - BIT_IDX_W'(tp));
            bit_v = nib[toff];
          end
        end
      end
    end else begin
      if (idx == BIT_IDX_W'(PROG_FIELD_BASE)) begin
        bit_v = prog_index[0];
      end else if (idx == BIT_IDX_W'(PROG_FIELD_BASE + 1)) begin
        bit_v = prog_index[1];
      end
    end
    return bit_v;
  endfunction

endpackage

[rtl/core/ibpt_front.sv]
// Front end: decodes an input beat and range-checks its command fields.
// Depends on ibpt_pkg.
module ibpt_front (
  input  logic [ibpt_pkg::IN_DATA_W-1:0] s_axis_tdata,  // zone, minutes, program
  input  logic [ibpt_pkg::IN_USER_W-1:0] s_axis_tuser,  // req_type
  output ibpt_pkg::cmd_t                 cmd
);
  import ibpt_pkg::*;

  logic [7:0] zone;
  logic [7:0] mins;
  logic [7:0] prog;

  assign zone = s_axis_tdata[7:0];
  assign mins = s_axis_tdata[15:8];
  assign prog = s_axis_tdata[23:16];

  always_comb begin
    cmd.req        = req_t'(s_axis_tuser);
    cmd.check      = ST_OK;
    cmd.zone_index = 6'(zone - 8'd1);
    cmd.minutes    = mins;
    cmd.prog_index = 2'(prog - 8'd1);
    case (cmd.req)
      REQ_ZONE: begin
        // zone checked before time
        if ((zone == 8'd0) || (zone > 8'(MAX_ZONE))) begin
          cmd.check = ST_BAD_ZONE;
        end else if (mins > 8'(MAX_MINUTES)) begin
          cmd.check = ST_BAD_TIME;
        end
      end
      REQ_PROG: begin
        if ((prog == 8'd0) || (prog > 8'(PROGRAM_COUNT))) begin
          cmd.check = ST_BAD_PROG;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/ibpt_queue.sv]
// Two-entry queue of classified commands between front end and engine.
// Depends on ibpt_pkg.
module ibpt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ibpt_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output ibpt_pkg::cmd_t pop_data,
  output logic           empty
);
  import ibpt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/ibpt_engine.sv]
// Back end: timing registers, frame sequencer and the output register.
// Depends on ibpt_pkg; fed by ibpt_queue.
module ibpt_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ibpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ibpt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ibpt_pkg::cmd_t                  cmd,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ibpt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ibpt_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_RST_HI   = 7'b0000010,
    PH_RST_LO   = 7'b0000100,
    PH_START_HI = 7'b0001000,
    PH_START_LO = 7'b0010000,
    PH_BIT_HI   = 7'b0100000,
    PH_BIT_LO   = 7'b1000000
  } phase_t;

  localparam logic [BIT_IDX_W-1:0] ZONE_TOTAL = BIT_IDX_W'(ZONE_FRAME_BITS + 1);
  localparam logic [BIT_IDX_W-1:0] PROG_TOTAL = BIT_IDX_W'(PROGRAM_FRAME_BITS);

  logic [SHORT_REG_W-1:0] short_ticks;
  logic [SHORT_REG_W-1:0] long_ticks;
  logic [SHORT_REG_W-1:0] start_ticks;
  logic [TICK_W-1:0]      reset_high_ticks;
  logic [TICK_W-1:0]      reset_low_ticks;

  phase_t                 phase, phase_next;
  logic [TICK_W-1:0]      tick_count, tick_count_next;
  logic [BIT_IDX_W-1:0]   bit_index, bit_index_next;
  logic                   frame_is_zone, frame_is_zone_next;
  logic [5:0]             zone_index, zone_index_next;
  logic [7:0]             minutes_held, minutes_held_next;
  logic [1:0]             program_index, program_index_next;

  logic                   cur_bit;
  logic [TICK_W-1:0]      cur_len;
  logic [TICK_W-1:0]      tick_inc;
  logic [BIT_IDX_W-1:0]   bit_inc;
  logic [BIT_IDX_W-1:0]   total;
  logic                   do_step;
  result_t                res_next;
  result_t                result;

  assign do_step       = cmd_valid && (!m_axis_tvalid || m_axis_tready);
  assign cmd_pop       = do_step;
  assign m_axis_tdata  = {1'b0, result};

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks      <= 16'd208;
      long_ticks       <= 16'd1875;
      start_ticks      <= 16'd900;
      reset_high_ticks <= 20'd325000;
      reset_low_ticks  <= 20'd65000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHORT:  short_ticks      <= cfg_data[SHORT_REG_W-1:0];
        CFG_LONG:   long_ticks       <= cfg_data[SHORT_REG_W-1:0];
        CFG_START:  start_ticks      <= cfg_data[SHORT_REG_W-1:0];
        CFG_RST_HI: reset_high_ticks <= cfg_data;
        CFG_RST_LO: reset_low_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_bit = frame_bit(frame_is_zone, bit_index, zone_index, minutes_held, program_index);
    case (phase)
      PH_RST_HI:   cur_len = reset_high_ticks;
      PH_RST_LO:   cur_len = reset_low_ticks;
      PH_START_HI: cur_len = TICK_W'(start_ticks);
      PH_START_LO: cur_len = TICK_W'(short_ticks);
      PH_BIT_HI:   cur_len = TICK_W'(cur_bit ? long_ticks : short_ticks);
      PH_BIT_LO:   cur_len = TICK_W'(cur_bit ? short_ticks : long_ticks);
      default:     cur_len = TICK_W'(1);
    endcase
    tick_inc = tick_count + 1'b1;
    bit_inc  = bit_index + 1'b1;
    total    = frame_is_zone ? ZONE_TOTAL : PROG_TOTAL;

    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    frame_is_zone_next = frame_is_zone;
    zone_index_next    = zone_index;
    minutes_held_next  = minutes_held;
    program_index_next = program_index;
    res_next           = '0;

    case (cmd.req)
      REQ_ZONE, REQ_PROG: begin
        res_next.status_valid = 1'b1;
        if (phase != PH_IDLE) begin
          res_next.status_code = ST_BUSY;
        end else if (cmd.check != ST_OK) begin
          res_next.status_code = cmd.check;
        end else begin
          frame_is_zone_next = (cmd.req == REQ_ZONE);
          if (cmd.req == REQ_ZONE) begin
            zone_index_next   = cmd.zone_index;
            minutes_held_next = cmd.minutes;
          end else begin
            program_index_next = cmd.prog_index;
          end
          phase_next      = PH_RST_HI;
          tick_count_next = '0;
          bit_index_next  = '0;
        end
      end
      REQ_TICK: begin
        if (phase != PH_IDLE) begin
          tick_count_next = tick_inc;
          // a zero length reads as one tick
          if (tick_inc >= cur_len) begin
            tick_count_next = '0;
            case (phase)
              PH_RST_HI:   phase_next = PH_RST_LO;
              PH_RST_LO:   phase_next = PH_START_HI;
              PH_START_HI: phase_next = PH_START_LO;
              PH_START_LO: begin
                phase_next     = PH_BIT_HI;
                bit_index_next = '0;
              end
              PH_BIT_HI:   phase_next = PH_BIT_LO;
              PH_BIT_LO: begin
                if (bit_inc >= total) begin
                  phase_next          = PH_IDLE;
                  bit_index_next      = '0;
                  res_next.frame_done = 1'b1;
                end else begin
                  phase_next     = PH_BIT_HI;
                  bit_index_next = bit_inc;
                end
              end
              default:     phase_next = PH_IDLE;
            endcase
          end
        end
      end
      default: ;
    endcase

    res_next.line_level = (phase_next == PH_RST_HI) || (phase_next == PH_START_HI) ||
                          (phase_next == PH_BIT_HI);
    res_next.busy_res   = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      frame_is_zone <= 1'b0;
      zone_index    <= '0;
      minutes_held  <= '0;
      program_index <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (do_step) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        frame_is_zone <= frame_is_zone_next;
        zone_index    <= zone_index_next;
        minutes_held  <= minutes_held_next;
        program_index <= program_index_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      result <= res_next;
    end
  end

  // a finished frame leaves the line low and idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.frame_done) |-> (!result.busy_res && !result.line_level))
    else $error("frame_done beat with line still busy");

  // no status code without a command answer
  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !result.status_valid) |-> (result.status_code == ST_OK))
    else $error("status code set without status_valid");

  // the sequencer moves only when a beat is processed
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !do_step |=> $stable(phase) && $stable(tick_count))
    else $error("sequencer advanced without a beat");

endmodule

[rtl/core/irrigation_bus_pulse_transmitter_unit.sv]
// An accepted beat waits in the queue; the engine then pops it and registers its result beat.
// Throughput: one input beat and one result beat per cycle when not stalled; the queue and
//   output register let either side stall independently, and the sequencer takes one beat a cycle.
// Reset (rst, synchronous, active high): frame idle, line low, queue empty, no result
//   pending, timing registers back to their defaults.
module irrigation_bus_pulse_transmitter_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [ibpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ibpt_pkg::CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] zone_number, [15:8] duration_minutes, [23:16] program_number
  input  logic [ibpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [ibpt_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // result beats
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] line_level, [1] busy_res, [2] status_valid, [5:3] status_code,
  // [6] frame_done, [7] zero
  output logic [ibpt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ibpt_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;
  logic push;

  // front accepts whenever the queue has a free slot
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // decode and range checks, independent of frame state
  ibpt_front u_front (
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd          (front_cmd)
  );

  ibpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (queue_cmd),
    .empty     (queue_empty)
  );

  // busy check, timer and bit sequencing happen here against the live state
  ibpt_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (queue_cmd),
    .cmd_valid     (!queue_empty),
    .cmd_pop       (queue_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
